>>> sv/ktr_pkg.sv
// Package for the keyword trie recognizer: node codes, class codes and the
// constant trie transition and class functions. Depends on nothing else.
package ktr_pkg;

    localparam int CharWidth  = 8;
    localparam int NodeWidth  = 8;
    localparam int ClassWidth = 5;

    typedef logic [CharWidth-1:0]  char_t;
    typedef logic [NodeWidth-1:0]  node_t;
    typedef logic [ClassWidth-1:0] class_t;

    localparam node_t  START_NODE = node_t'(0);
    localparam node_t  DEAD_NODE  = node_t'(255);
    localparam char_t  WORD_END   = char_t'(0);

    localparam class_t CLASS_IDENT  = class_t'(0);
    localparam class_t CLASS_NOISE  = class_t'(31);

    // Next node of the trie for one character. Any pair that is not an
    // edge of the trie, and every character in the dead node, goes dead.
    function automatic node_t trie_next(input node_t state, input char_t ch);
        node_t nxt;
        nxt = DEAD_NODE;
        unique case ({state, ch})
            {8'd0,   "a"}: nxt = 8'd1;
            {8'd1,   "n"}: nxt = 8'd2;
            {8'd2,   "d"}: nxt = 8'd3;
            {8'd0,   "o"}: nxt = 8'd4;
            {8'd4,   "r"}: nxt = 8'd5;
            {8'd0,   "n"}: nxt = 8'd6;
            {8'd6,   "o"}: nxt = 8'd7;
            {8'd7,   "t"}: nxt = 8'd8;
            {8'd8,   "h"}: nxt = 8'd9;
            {8'd9,   "i"}: nxt = 8'd10;
            {8'd10,  "n"}: nxt = 8'd11;
            {8'd11,  "g"}: nxt = 8'd12;
            {8'd0,   "i"}: nxt = 8'd13;
            {8'd13,  "f"}: nxt = 8'd14;
            {8'd13,  "n"}: nxt = 8'd15;
            {8'd15,  "c"}: nxt = 8'd16;
            {8'd16,  "l"}: nxt = 8'd17;
            {8'd17,  "u"}: nxt = 8'd18;
            {8'd18,  "d"}: nxt = 8'd19;
            {8'd19,  "e"}: nxt = 8'd20;
            {8'd0,   "e"}: nxt = 8'd21;
            {8'd21,  "l"}: nxt = 8'd22;
            {8'd22,  "s"}: nxt = 8'd23;
            {8'd23,  "e"}: nxt = 8'd24;
            {8'd22,  "i"}: nxt = 8'd25;
            {8'd25,  "f"}: nxt = 8'd26;
            {8'd0,   "r"}: nxt = 8'd27;
            {8'd27,  "e"}: nxt = 8'd28;
            {8'd28,  "p"}: nxt = 8'd29;
            {8'd29,  "e"}: nxt = 8'd30;
            {8'd30,  "a"}: nxt = 8'd31;
            {8'd31,  "t"}: nxt = 8'd32;
            {8'd32,  "f"}: nxt = 8'd33;
            {8'd33,  "o"}: nxt = 8'd34;
            {8'd34,  "r"}: nxt = 8'd35;
            {8'd0,   "s"}: nxt = 8'd36;
            {8'd36,  "t"}: nxt = 8'd37;
            {8'd37,  "o"}: nxt = 8'd38;
            {8'd38,  "p"}: nxt = 8'd39;
            {8'd37,  "a"}: nxt = 8'd40;
            {8'd40,  "t"}: nxt = 8'd41;
            {8'd41,  "i"}: nxt = 8'd42;
            {8'd42,  "c"}: nxt = 8'd43;
            {8'd36,  "y"}: nxt = 8'd44;
            {8'd44,  "m"}: nxt = 8'd45;
            {8'd45,  "b"}: nxt = 8'd46;
            {8'd46,  "o"}: nxt = 8'd47;
            {8'd47,  "l"}: nxt = 8'd48;
            {8'd0,   "c"}: nxt = 8'd49;
            {8'd49,  "o"}: nxt = 8'd50;
            {8'd50,  "n"}: nxt = 8'd51;
            {8'd51,  "t"}: nxt = 8'd52;
            {8'd52,  "i"}: nxt = 8'd53;
            {8'd53,  "n"}: nxt = 8'd54;
            {8'd54,  "u"}: nxt = 8'd55;
            {8'd55,  "e"}: nxt = 8'd56;
            {8'd0,   "f"}: nxt = 8'd57;
            {8'd57,  "u"}: nxt = 8'd58;
            {8'd58,  "n"}: nxt = 8'd59;
            {8'd59,  "c"}: nxt = 8'd60;
            {8'd60,  "t"}: nxt = 8'd61;
            {8'd61,  "i"}: nxt = 8'd62;
            {8'd62,  "o"}: nxt = 8'd63;
            {8'd63,  "n"}: nxt = 8'd64;
            {8'd57,  "a"}: nxt = 8'd65;
            {8'd65,  "l"}: nxt = 8'd66;
            {8'd66,  "s"}: nxt = 8'd67;
            {8'd67,  "e"}: nxt = 8'd68;
            {8'd0,   "g"}: nxt = 8'd69;
            {8'd69,  "i"}: nxt = 8'd70;
            {8'd70,  "v"}: nxt = 8'd71;
            {8'd71,  "e"}: nxt = 8'd72;
            {8'd69,  "e"}: nxt = 8'd73;
            {8'd73,  "t"}: nxt = 8'd74;
            {8'd0,   "d"}: nxt = 8'd75;
            {8'd75,  "i"}: nxt = 8'd76;
            {8'd76,  "s"}: nxt = 8'd77;
            {8'd77,  "p"}: nxt = 8'd78;
            {8'd78,  "l"}: nxt = 8'd79;
            {8'd79,  "a"}: nxt = 8'd80;
            {8'd80,  "y"}: nxt = 8'd81;
            {8'd75,  "e"}: nxt = 8'd82;
            {8'd82,  "c"}: nxt = 8'd83;
            {8'd83,  "i"}: nxt = 8'd84;
            {8'd84,  "m"}: nxt = 8'd85;
            {8'd85,  "a"}: nxt = 8'd86;
            {8'd86,  "l"}: nxt = 8'd87;
            {8'd6,   "u"}: nxt = 8'd88;
            {8'd88,  "m"}: nxt = 8'd89;
            {8'd89,  "b"}: nxt = 8'd90;
            {8'd90,  "e"}: nxt = 8'd91;
            {8'd91,  "r"}: nxt = 8'd92;
            {8'd92,  "a"}: nxt = 8'd93;
            {8'd93,  "c"}: nxt = 8'd94;
            {8'd94,  "i"}: nxt = 8'd95;
            {8'd95,  "m"}: nxt = 8'd96;
            {8'd96,  "a"}: nxt = 8'd97;
            {8'd97,  "l"}: nxt = 8'd98;
            {8'd4,   "n"}: nxt = 8'd99;
            {8'd99,  "f"}: nxt = 8'd100;
            {8'd100, "a"}: nxt = 8'd101;
            {8'd101, "i"}: nxt = 8'd102;
            {8'd102, "l"}: nxt = 8'd103;
            {8'd0,   "b"}: nxt = 8'd104;
            {8'd104, "o"}: nxt = 8'd105;
            {8'd105, "o"}: nxt = 8'd106;
            {8'd106, "l"}: nxt = 8'd107;
            {8'd104, "u"}: nxt = 8'd108;
            {8'd108, "n"}: nxt = 8'd109;
            {8'd109, "d"}: nxt = 8'd110;
            {8'd110, "l"}: nxt = 8'd111;
            {8'd111, "e"}: nxt = 8'd112;
            {8'd0,   "t"}: nxt = 8'd113;
            {8'd113, "e"}: nxt = 8'd114;
            {8'd114, "x"}: nxt = 8'd115;
            {8'd115, "t"}: nxt = 8'd116;
            {8'd113, "r"}: nxt = 8'd117;
            {8'd117, "u"}: nxt = 8'd118;
            {8'd118, "e"}: nxt = 8'd119;
            {8'd117, "y"}: nxt = 8'd120;
            {8'd0,   "l"}: nxt = 8'd121;
            {8'd121, "i"}: nxt = 8'd122;
            {8'd122, "s"}: nxt = 8'd123;
            {8'd123, "t"}: nxt = 8'd124;
            {8'd0,   "v"}: nxt = 8'd125;
            {8'd125, "o"}: nxt = 8'd126;
            {8'd126, "i"}: nxt = 8'd127;
            {8'd127, "d"}: nxt = 8'd128;
            {8'd113, "h"}: nxt = 8'd129;
            {8'd129, "e"}: nxt = 8'd130;
            {8'd130, "n"}: nxt = 8'd131;
            {8'd21,  "n"}: nxt = 8'd132;
            {8'd132, "d"}: nxt = 8'd133;
            {8'd40,  "r"}: nxt = 8'd134;
            {8'd134, "t"}: nxt = 8'd135;
            {8'd36,  "o"}: nxt = 8'd136;
            default:       nxt = DEAD_NODE;
        endcase
        return nxt;
    endfunction

    // Word class of a node. Nodes that end no keyword, and the dead node,
    // give the identifier class.
    function automatic class_t trie_class(input node_t state);
        class_t cls;
        cls = CLASS_IDENT;
        unique case (state)
            8'd3:   cls = class_t'(1);
            8'd5:   cls = class_t'(2);
            8'd8:   cls = class_t'(3);
            8'd12:  cls = class_t'(4);
            8'd14:  cls = class_t'(5);
            8'd15:  cls = class_t'(6);
            8'd20:  cls = class_t'(7);
            8'd24:  cls = class_t'(8);
            8'd26:  cls = class_t'(9);
            8'd32:  cls = class_t'(10);
            8'd35:  cls = class_t'(11);
            8'd39:  cls = class_t'(12);
            8'd43:  cls = class_t'(13);
            8'd48:  cls = class_t'(14);
            8'd56:  cls = class_t'(15);
            8'd64:  cls = class_t'(16);
            8'd68:  cls = class_t'(17);
            8'd72:  cls = class_t'(18);
            8'd74:  cls = class_t'(19);
            8'd81:  cls = class_t'(20);
            8'd87:  cls = class_t'(21);
            8'd98:  cls = class_t'(21);
            8'd103: cls = class_t'(22);
            8'd92:  cls = class_t'(23);
            8'd107: cls = class_t'(24);
            8'd112: cls = class_t'(25);
            8'd116: cls = class_t'(26);
            8'd119: cls = class_t'(27);
            8'd120: cls = class_t'(28);
            8'd124: cls = class_t'(29);
            8'd128: cls = class_t'(30);
            8'd131: cls = CLASS_NOISE;
            8'd133: cls = CLASS_NOISE;
            8'd135: cls = CLASS_NOISE;
            8'd136: cls = CLASS_NOISE;
            default: cls = CLASS_IDENT;
        endcase
        return cls;
    endfunction

endpackage

>>> sv/keyword_trie_recognizer.sv
// Keyword trie recognizer, top level: input register, trie walker, result register.
// Throughput: one character per cycle; the trie step is one case lookup. A word end
// waits in the input register until the result register has room for its class.
// Reset clears both valid flags and returns the trie to its start node.
// Depends on ktr_pkg and ktr_trie_walk.
module keyword_trie_recognizer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            char_valid,
    output logic            char_stall,
    input  ktr_pkg::char_t  char_in,
    output logic            token_valid,
    input  logic            token_stall,
    output ktr_pkg::class_t token_class
);
    import ktr_pkg::*;

    // Input stage: one registered character request.
    logic   in_vld_reg;
    logic   in_vld_next;
    char_t  char_reg;

    // Result stage: one registered class waiting to be taken.
    logic   out_vld_reg;
    logic   out_vld_next;
    class_t class_reg;

    logic   take;
    logic   step;
    logic   word_done;
    class_t word_class;
    logic   out_free;

    // The result register is free when empty or being taken this cycle.
    // A plain character produces no result and can always step the trie;
    // only a word end has to wait for room in the result register.
    assign out_free   = !out_vld_reg || !token_stall;
    assign step       = in_vld_reg && (!word_done || out_free);
    assign char_stall = in_vld_reg && !step;
    assign take       = char_valid && !char_stall;

    ktr_trie_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .ch         (char_reg),
        .word_done  (word_done),
        .word_class (word_class)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (take)
        begin
            in_vld_next = 1'b1;
        end
        else if (step)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (step && word_done)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_vld_reg && !token_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= char_in;
        end
        if (step && word_done)
        begin
            class_reg <= word_class;
        end
    end

    assign token_valid = out_vld_reg;
    assign token_class = class_reg;

endmodule

>>> sv/ktr_trie_walk.sv
// Trie walker: holds the current trie node and moves it one edge per character.
// Depends on ktr_pkg for the transition and class functions.
module ktr_trie_walk (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  ktr_pkg::char_t  ch,
    output logic            word_done,
    output ktr_pkg::class_t word_class
);
    import ktr_pkg::*;

    node_t node_reg;
    node_t node_next;

    // A word end reports the class of the node reached and restarts.
    always_comb
    begin
        word_done  = (ch == WORD_END);
        word_class = trie_class(node_reg);
        node_next  = node_reg;
        if (step)
        begin
            if (word_done)
            begin
                node_next = START_NODE;
            end
            else
            begin
                node_next = trie_next(node_reg, ch);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_reg <= START_NODE;
        end
        else
        begin
            node_reg <= node_next;
        end
    end

endmodule
